/* hdl/idle_backlight_dim_ramp_core_macros.svh */
// Assertion macros shared by the idle-dimming backlight controller.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef IDLE_BACKLIGHT_DIM_RAMP_CORE_MACROS_SVH
`define IDLE_BACKLIGHT_DIM_RAMP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IBDR_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ibdr same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IBDR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ibdr next-cycle check failed");

`endif

/* hdl/ibdr_pkg.sv */
// Shared types, constants and light profile tables of the backlight controller.
// Depends on nothing.
package ibdr_pkg;

    localparam int LEVEL_W  = 15;   // percent times 256
    localparam int INC_W    = 16;   // signed increment, 8 fraction bits
    localparam int STEP_W   = 7;
    localparam int LUX_W    = 17;
    localparam int PROF_W   = 4;
    localparam int REQ_W    = 3;
    localparam int TIMER_W  = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int CNT_W    = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 15'd25600;
    localparam logic [STEP_W-1:0]  MAX_PCT    = 7'd100;

    localparam int PROFILE_COUNT  = 9;
    localparam int LUX_HYSTERESIS = 10;

    localparam logic [LUX_W-1:0] PROF_MIN_LUX [PROFILE_COUNT] = '{
        17'd0, 17'd11, 17'd51, 17'd201, 17'd401, 17'd1001, 17'd5001, 17'd10001, 17'd30001
    };
    localparam logic [STEP_W-1:0] PROF_SCREEN [PROFILE_COUNT] = '{
        7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };
    localparam logic [STEP_W-1:0] PROF_KBD [PROFILE_COUNT] = '{
        7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_ACTIVITY = 3'd1,
        REQ_FORCE_DIM = 3'd2,
        REQ_FORCE_BRT = 3'd3,
        REQ_LUX      = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        REG_IDLE_TIMEOUT  = 3'd0,
        REG_DIM_PERCENT   = 3'd1,
        REG_DIM_STEPS     = 3'd2,
        REG_BRT_STEPS     = 3'd3,
        REG_SCREEN_EN     = 3'd4,
        REG_KBD_EN        = 3'd5,
        REG_LIGHT_SENS_EN = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic               start;
        logic [INC_W-1:0]   dividend;   // two's complement
        logic [STEP_W-1:0]  divisor;    // never zero
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [INC_W-1:0]   quotient;   // truncated toward zero
    } t_div_rsp;

endpackage

/* hdl/idle_backlight_dim_ramp_core.sv */
// Top level of the idle-dimming backlight controller: sequencer, state, APB registers.
// Depends on ibdr_pkg, ibdr_div and idle_backlight_dim_ramp_core_macros.svh.
//
// The controller takes one request at a time (tick, user activity, forced dim,
// forced brighten or lux sample) and answers each with one result carrying the
// screen and keyboard levels (percent times 256), the dimmed and ramping flags
// and the last chosen light profile. A request that starts no ramp passes the
// states accept, execute and deliver on its way to the result register. When a
// ramp starts, each channel that moves needs its increment (goal - level) / steps,
// which one shared divider produces at one quotient bit per cycle; the screen and
// keyboard divisions run one after the other between execute and deliver. The
// result sits in an output register, so the next request is taken while an
// earlier result still waits for the consumer. Configuration lives behind an APB
// port with zero wait states; registers sit at byte address 4 times their index
// and must only be written while the controller is idle.
module idle_backlight_dim_ramp_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ibdr_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ibdr_pkg::LUX_W-1:0]   i_lux_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ibdr_pkg::LEVEL_W-1:0] o_screen_level,
    output logic [ibdr_pkg::LEVEL_W-1:0] o_kbd_level,
    output logic                         o_is_dimmed,
    output logic                         o_is_ramping,
    output logic [ibdr_pkg::PROF_W-1:0]  o_profile_index,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ibdr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ibdr_pkg::DATA_W-1:0]  pwdata,
    output logic [ibdr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import ibdr_pkg::*;

    `include "idle_backlight_dim_ramp_core_macros.svh"

    // Sequencer states. The two GO states launch the divider for the screen and
    // keyboard increments; the WAIT states collect the quotient.
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_SCR_GO   = 7'b0000100,
        S_SCR_WAIT = 7'b0001000,
        S_KBD_GO   = 7'b0010000,
        S_KBD_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    // Whole percent drops the fraction; rounded percent adds one half first.
    function automatic logic [STEP_W:0] f_round_pct(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W:0] s;
        s = {1'b0, v} + (LEVEL_W+1)'(128);
        return s[LEVEL_W:8];
    endfunction

    // Configuration registers.
    logic [TIMER_W-1:0] r_idle_timeout;
    logic [STEP_W-1:0]  r_dim_percent, r_dim_steps, r_brt_steps;
    logic               r_screen_en, r_kbd_en, r_lsen;
    logic               w_cfg_wr;

    // Sequencer and controller state.
    t_state             r_state, n_state;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [LUX_W-1:0]   r_lux, n_lux;
    logic [TIMER_W-1:0] r_idle, n_idle;
    logic               r_dimmed, n_dimmed;
    logic [LEVEL_W-1:0] r_snow, n_snow, r_know, n_know;
    logic [LEVEL_W-1:0] r_ssaved, n_ssaved, r_ksaved, n_ksaved;
    logic [LEVEL_W-1:0] r_sgoal, n_sgoal, r_kgoal, n_kgoal;
    logic [INC_W-1:0]   r_sinc, n_sinc, r_kinc, n_kinc;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic               r_abort, n_abort;
    logic               r_smove, n_smove, r_kmove, n_kmove;
    logic [LUX_W-1:0]   r_last_lux, n_last_lux;
    logic               r_lux_seen, n_lux_seen;
    logic [PROF_W-1:0]  r_profile, n_profile;

    // Result register.
    logic               r_out_valid, n_out_valid;
    logic               n_load;
    logic [LEVEL_W-1:0] r_o_screen, r_o_kbd;
    logic               r_o_dimmed, r_o_ramping;
    logic [PROF_W-1:0]  r_o_profile;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    ibdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // APB configuration: zero wait states, write on the access phase.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_IDLE_TIMEOUT:  prdata = r_idle_timeout;
            REG_DIM_PERCENT:   prdata = DATA_W'(r_dim_percent);
            REG_DIM_STEPS:     prdata = DATA_W'(r_dim_steps);
            REG_BRT_STEPS:     prdata = DATA_W'(r_brt_steps);
            REG_SCREEN_EN:     prdata = DATA_W'(r_screen_en);
            REG_KBD_EN:        prdata = DATA_W'(r_kbd_en);
            REG_LIGHT_SENS_EN: prdata = DATA_W'(r_lsen);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= TIMER_W'(120);
            r_dim_percent  <= STEP_W'(10);
            r_dim_steps    <= STEP_W'(20);
            r_brt_steps    <= STEP_W'(5);
            r_screen_en    <= 1'b1;
            r_kbd_en       <= 1'b0;
            r_lsen         <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_IDLE_TIMEOUT:  r_idle_timeout <= pwdata;
                REG_DIM_PERCENT:   r_dim_percent  <= pwdata[STEP_W-1:0];
                REG_DIM_STEPS:     r_dim_steps    <= pwdata[STEP_W-1:0];
                REG_BRT_STEPS:     r_brt_steps    <= pwdata[STEP_W-1:0];
                REG_SCREEN_EN:     r_screen_en    <= pwdata[0];
                REG_KBD_EN:        r_kbd_en       <= pwdata[0];
                REG_LIGHT_SENS_EN: r_lsen         <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. The execute cycle applies the whole request to the state
    // (ramp advance, idle count, dim, brighten, profile choice) and decides
    // whether a ramp starts. The increments of the moving channels are then
    // filled in one after the other by the shared divider.
    // ------------------------------------------------------------------
    always_comb begin
        logic [LEVEL_W-1:0] v_snow, v_know, v_sgoal, v_kgoal, v_ts, v_tk;
        logic [INC_W-1:0]   v_ssum, v_ksum;
        logic [STEP_W-1:0]  v_steps, v_eff, v_pct;
        logic               v_go, v_abort, v_dim, v_brt, v_forced, v_smove, v_kmove;
        logic [TIMER_W-1:0] v_idle;
        logic [LUX_W-1:0]   v_diff;
        logic [PROF_W-1:0]  v_pick;

        n_state    = r_state;
        n_req      = r_req;
        n_lux      = r_lux;
        n_idle     = r_idle;
        n_dimmed   = r_dimmed;
        n_snow     = r_snow;
        n_know     = r_know;
        n_ssaved   = r_ssaved;
        n_ksaved   = r_ksaved;
        n_sgoal    = r_sgoal;
        n_kgoal    = r_kgoal;
        n_sinc     = r_sinc;
        n_kinc     = r_kinc;
        n_steps    = r_steps;
        n_abort    = r_abort;
        n_smove    = r_smove;
        n_kmove    = r_kmove;
        n_last_lux = r_last_lux;
        n_lux_seen = r_lux_seen;
        n_profile  = r_profile;
        n_out_valid = r_out_valid && !i_out_ready;
        n_load     = 1'b0;

        w_div_req.start    = 1'b0;
        w_div_req.divisor  = r_steps;
        w_div_req.dividend = {1'b0, r_sgoal} - {1'b0, r_snow};

        v_snow   = r_snow;
        v_know   = r_know;
        v_sgoal  = r_snow;
        v_kgoal  = r_know;
        v_ts     = r_ssaved;
        v_tk     = r_ksaved;
        v_ssum   = {1'b0, r_snow} + r_sinc;
        v_ksum   = {1'b0, r_know} + r_kinc;
        v_steps  = r_dim_steps;
        v_eff    = r_dim_steps;
        v_pct    = (r_dim_percent > MAX_PCT) ? MAX_PCT : r_dim_percent;
        v_go     = 1'b0;
        v_abort  = 1'b0;
        v_dim    = 1'b0;
        v_brt    = 1'b0;
        v_forced = 1'b0;
        v_smove  = 1'b0;
        v_kmove  = 1'b0;
        v_idle   = r_idle;
        v_diff   = (r_lux > r_last_lux) ? (r_lux - r_last_lux) : (r_last_lux - r_lux);
        v_pick   = '0;
        for (int i = 0; i < PROFILE_COUNT; i++) begin
            if (r_lux >= PROF_MIN_LUX[i]) begin
                v_pick = PROF_W'(i);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_lux   = i_lux_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req)
                    REQ_TICK: begin
                        // The ramp moves first; its last step lands on the goal.
                        if (r_steps != '0) begin
                            n_steps = r_steps - 1'b1;
                            if (r_steps == STEP_W'(1)) begin
                                v_snow  = r_sgoal;
                                v_know  = r_kgoal;
                                n_abort = 1'b0;
                            end else begin
                                v_snow = v_ssum[LEVEL_W-1:0];
                                v_know = v_ksum[LEVEL_W-1:0];
                            end
                        end
                        if (!r_dimmed) begin
                            v_idle = (r_idle == '1) ? r_idle : r_idle + 1'b1;
                            n_idle = v_idle;
                            if (v_idle >= r_idle_timeout && (r_screen_en || r_kbd_en)) begin
                                v_dim = 1'b1;
                            end
                        end
                    end
                    REQ_ACTIVITY: begin
                        n_idle = '0;
                        if (r_abort && r_steps != '0) begin
                            n_steps = '0;
                            n_abort = 1'b0;
                        end
                        v_brt = 1'b1;
                    end
                    REQ_FORCE_DIM: begin
                        v_dim    = 1'b1;
                        v_forced = 1'b1;
                    end
                    REQ_FORCE_BRT: begin
                        v_brt    = 1'b1;
                        v_forced = 1'b1;
                    end
                    REQ_LUX: begin
                        if (r_lsen && !r_dimmed) begin
                            if (r_lux_seen && v_diff < LUX_W'(LUX_HYSTERESIS)) begin
                                n_last_lux = r_lux;
                            end else begin
                                if (r_kbd_en && f_round_pct(r_ksaved) != {1'b0, PROF_KBD[v_pick]}) begin
                                    v_tk = {PROF_KBD[v_pick], 8'h00};
                                end
                                if (f_round_pct(r_ssaved) != {1'b0, PROF_SCREEN[v_pick]}) begin
                                    v_ts = {PROF_SCREEN[v_pick], 8'h00};
                                end
                                if (f_round_pct(r_ksaved) != f_round_pct(v_tk)
                                        || f_round_pct(r_ssaved) != f_round_pct(v_ts)
                                        || (v_tk[7:0] != 8'h00 && v_tk != r_ksaved)
                                        || (v_ts[7:0] != 8'h00 && v_ts != r_ssaved)) begin
                                    v_go    = 1'b1;
                                    v_sgoal = v_ts;
                                    v_kgoal = v_tk;
                                    v_steps = r_dim_steps;
                                    v_abort = 1'b0;
                                end
                                n_ssaved   = v_ts;
                                n_ksaved   = v_tk;
                                n_profile  = v_pick;
                                n_last_lux = r_lux;
                                n_lux_seen = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase

                // Entering dimmed mode saves the levels it is about to lower.
                if (v_dim && !r_dimmed) begin
                    if (r_screen_en) begin
                        n_ssaved = v_snow;
                    end
                    if (r_kbd_en) begin
                        n_ksaved = v_know;
                    end
                    v_go     = 1'b1;
                    v_sgoal  = {v_pct, 8'h00};
                    v_kgoal  = '0;
                    v_steps  = v_forced ? STEP_W'(1) : r_dim_steps;
                    v_abort  = 1'b1;
                    n_dimmed = 1'b1;
                end

                if (v_brt && r_dimmed) begin
                    n_idle   = '0;
                    v_go     = 1'b1;
                    v_sgoal  = r_ssaved;
                    v_kgoal  = r_ksaved;
                    v_steps  = v_forced ? STEP_W'(1) : r_brt_steps;
                    v_abort  = 1'b0;
                    n_dimmed = 1'b0;
                end

                n_snow = v_snow;
                n_know = v_know;

                // Ramp start: a channel moves only when its whole percent changes.
                if (v_go) begin
                    v_eff   = (v_steps == '0) ? STEP_W'(1) : v_steps;
                    v_smove = (r_screen_en || r_lsen)
                              && (v_sgoal[LEVEL_W-1:8] != v_snow[LEVEL_W-1:8]);
                    v_kmove = r_kbd_en && (v_kgoal[LEVEL_W-1:8] != v_know[LEVEL_W-1:8]);
                    n_sgoal = v_smove ? v_sgoal : v_snow;
                    n_kgoal = v_kmove ? v_kgoal : v_know;
                    n_sinc  = '0;
                    n_kinc  = '0;
                    if (v_smove || v_kmove) begin
                        n_steps = v_eff;
                        n_abort = v_abort;
                    end else begin
                        n_steps = '0;
                        n_abort = 1'b0;
                    end
                end
                n_smove = v_smove;
                n_kmove = v_kmove;

                if (v_smove) begin
                    n_state = S_SCR_GO;
                end else if (v_kmove) begin
                    n_state = S_KBD_GO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCR_GO: begin
                w_div_req.start = 1'b1;
                n_state = S_SCR_WAIT;
            end
            S_SCR_WAIT: begin
                if (w_div_rsp.done) begin
                    n_sinc  = w_div_rsp.quotient;
                    n_state = r_kmove ? S_KBD_GO : S_DONE;
                end
            end
            S_KBD_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {1'b0, r_kgoal} - {1'b0, r_know};
                n_state = S_KBD_WAIT;
            end
            S_KBD_WAIT: begin
                if (w_div_rsp.done) begin
                    n_kinc  = w_div_rsp.quotient;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle      <= '0;
            r_dimmed    <= 1'b0;
            r_snow      <= FULL_LEVEL;
            r_know      <= '0;
            r_ssaved    <= FULL_LEVEL;
            r_ksaved    <= '0;
            r_sgoal     <= FULL_LEVEL;
            r_kgoal     <= '0;
            r_sinc      <= '0;
            r_kinc      <= '0;
            r_steps     <= '0;
            r_abort     <= 1'b0;
            r_smove     <= 1'b0;
            r_kmove     <= 1'b0;
            r_last_lux  <= '0;
            r_lux_seen  <= 1'b0;
            r_profile   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idle      <= n_idle;
            r_dimmed    <= n_dimmed;
            r_snow      <= n_snow;
            r_know      <= n_know;
            r_ssaved    <= n_ssaved;
            r_ksaved    <= n_ksaved;
            r_sgoal     <= n_sgoal;
            r_kgoal     <= n_kgoal;
            r_sinc      <= n_sinc;
            r_kinc      <= n_kinc;
            r_steps     <= n_steps;
            r_abort     <= n_abort;
            r_smove     <= n_smove;
            r_kmove     <= n_kmove;
            r_last_lux  <= n_last_lux;
            r_lux_seen  <= n_lux_seen;
            r_profile   <= n_profile;
            r_out_valid <= n_out_valid;
        end
        r_req <= n_req;
        r_lux <= n_lux;
        if (n_load) begin
            r_o_screen  <= r_snow;
            r_o_kbd     <= r_know;
            r_o_dimmed  <= r_dimmed;
            r_o_ramping <= (r_steps != '0);
            r_o_profile <= r_profile;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_screen_level  = r_o_screen;
    assign o_kbd_level     = r_o_kbd;
    assign o_is_dimmed     = r_o_dimmed;
    assign o_is_ramping    = r_o_ramping;
    assign o_profile_index = r_o_profile;

    // ------------------------------------------------------------------
    // Checks on the sequencer.
    // ------------------------------------------------------------------
    `IBDR_ASSERT_NEXT(a_accept_goes_exec, i_in_valid && o_in_ready, r_state == S_EXEC)
    `IBDR_ASSERT_IMPLY(a_div_quiet_when_idle, r_state == S_IDLE, !w_div_rsp.busy)
    `IBDR_ASSERT_IMPLY(a_dim_only_from_exec, $rose(r_dimmed), $past(r_state) == S_EXEC)

endmodule

/* hdl/ibdr_div.sv */
// Radix-2 restoring divider for ramp increments, one quotient bit per cycle.
// Depends on ibdr_pkg.
module ibdr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ibdr_pkg::t_div_req i_req,
    output ibdr_pkg::t_div_rsp o_rsp
);
    import ibdr_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEVEL_W-1:0] r_quo, n_quo;
    logic [STEP_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]  r_dvs, n_dvs;

    logic [STEP_W:0]    w_trial;
    logic [INC_W-1:0]   w_mag;
    logic [INC_W-1:0]   w_quo_ext;

    assign w_trial   = {r_rem, r_quo[LEVEL_W-1]};
    assign w_mag     = i_req.dividend[INC_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_quo_ext = {1'b0, r_quo};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_neg  = i_req.dividend[INC_W-1];
            n_cnt  = '0;
            n_quo  = w_mag[LEVEL_W-1:0];
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = STEP_W'(w_trial - {1'b0, r_dvs});
                n_quo = {r_quo[LEVEL_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[STEP_W-1:0];
                n_quo = {r_quo[LEVEL_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(LEVEL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~w_quo_ext + 1'b1) : w_quo_ext;

endmodule
